FILE: hdl/fstc_pkg.sv
// ----------------------------------------------------------------------------
// fstc_pkg
// Shared types and constants of the flow statistics tree classifier.
// ----------------------------------------------------------------------------
package fstc_pkg;

    localparam int FLOW_SLOTS    = 1024;
    localparam int FLOW_SLOT_W   = $clog2(FLOW_SLOTS);
    localparam int TREE_NODES    = 256;
    localparam int TREE_IDX_W    = $clog2(TREE_NODES);
    localparam int TREE_DEPTH    = 16;
    localparam int DEPTH_W       = $clog2(TREE_DEPTH + 1);
    localparam int FEATURE_COUNT = 8;
    localparam int FEAT_IDX_W    = $clog2(FEATURE_COUNT);
    localparam int FRAC_BITS     = 16;

    localparam int            NS_PER_US = 1000;
    localparam int            REM_W     = 10;
    localparam int            DIV_NIB   = 4;
    localparam int            DIV_STEPS = 64 / DIV_NIB;
    localparam int            DIV_CNT_W = $clog2(DIV_STEPS);
    localparam logic [63:0]   NO_GAP    = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam int            LINK_W    = 30;
    localparam logic [2:0]    NODE_COUNT_ADDR = 3'd0;

    localparam logic          MODE_NODE   = 1'b0;
    localparam logic          MODE_PACKET = 1'b1;

    typedef struct packed {
        logic        valid;
        logic [63:0] start_time;
        logic [63:0] last_time;
        logic [63:0] min_gap;
        logic [31:0] packets;
        logic [47:0] bytes;
        logic [15:0] len_max;
        logic [15:0] len_min;
    } flow_rec_t;

    typedef struct packed {
        logic [LINK_W-1:0] links;
        logic [63:0]       threshold;
    } tree_node_t;

    typedef struct packed {
        logic        start;
        logic [63:0] dur_ns;
        logic [63:0] gap_ns;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] dur_us;
        logic [63:0] gap_us;
    } div_rsp_t;

endpackage

FILE: hdl/fstc_flow_mem.sv
// ----------------------------------------------------------------------------
// fstc_flow_mem
// Flow record memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module fstc_flow_mem
(
    input  logic                             clk,
    input  logic                             rd_en,
    input  logic [fstc_pkg::FLOW_SLOT_W-1:0] rd_addr,
    output fstc_pkg::flow_rec_t              rd_data,
    input  logic                             wr_en,
    input  logic [fstc_pkg::FLOW_SLOT_W-1:0] wr_addr,
    input  fstc_pkg::flow_rec_t              wr_data
);

    fstc_pkg::flow_rec_t mem [fstc_pkg::FLOW_SLOTS];
    fstc_pkg::flow_rec_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/fstc_tree_mem.sv
// ----------------------------------------------------------------------------
// fstc_tree_mem
// Decision tree node memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module fstc_tree_mem
(
    input  logic                            clk,
    input  logic                            rd_en,
    input  logic [fstc_pkg::TREE_IDX_W-1:0] rd_addr,
    output fstc_pkg::tree_node_t            rd_data,
    input  logic                            wr_en,
    input  logic [fstc_pkg::TREE_IDX_W-1:0] wr_addr,
    input  fstc_pkg::tree_node_t            wr_data
);

    fstc_pkg::tree_node_t mem [fstc_pkg::TREE_NODES];
    fstc_pkg::tree_node_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/fstc_div1000.sv
// ----------------------------------------------------------------------------
// fstc_div1000
// Two-lane restoring divider by 1000, four quotient bits per cycle.
// ----------------------------------------------------------------------------
module fstc_div1000
(
    input  logic                clk,
    input  logic                rst_n,
    input  fstc_pkg::div_req_t  req,
    output fstc_pkg::div_rsp_t  rsp
);

    localparam logic [fstc_pkg::REM_W:0] DIVISOR = (fstc_pkg::REM_W + 1)'(fstc_pkg::NS_PER_US);

    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic [fstc_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [63:0]                      a_reg, a_next, b_reg, b_next;
    logic [fstc_pkg::REM_W-1:0]       ra_reg, ra_next, rb_reg, rb_next;

    function automatic logic [fstc_pkg::REM_W+fstc_pkg::DIV_NIB-1:0] step
        (input logic [fstc_pkg::REM_W-1:0] rem, input logic [fstc_pkg::DIV_NIB-1:0] nib);
        logic [fstc_pkg::REM_W:0]       r;
        logic [fstc_pkg::DIV_NIB-1:0]   q;
        r = {1'b0, rem};
        q = '0;
        for (int k = fstc_pkg::DIV_NIB - 1; k >= 0; k--)
        begin
            r = {r[fstc_pkg::REM_W-1:0], nib[k]};
            if (r >= DIVISOR)
            begin
                r    = r - DIVISOR;
                q[k] = 1'b1;
            end
        end
        return {r[fstc_pkg::REM_W-1:0], q};
    endfunction

    always_comb
    begin
        logic [fstc_pkg::REM_W+fstc_pkg::DIV_NIB-1:0] sa, sb;
        sa        = step(ra_reg, a_reg[63 -: fstc_pkg::DIV_NIB]);
        sb        = step(rb_reg, b_reg[63 -: fstc_pkg::DIV_NIB]);
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        ra_next   = ra_reg;
        rb_next   = rb_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            a_next    = req.dur_ns;
            b_next    = req.gap_ns;
            ra_next   = '0;
            rb_next   = '0;
        end
        else if (busy_reg)
        begin
            a_next   = {a_reg[63-fstc_pkg::DIV_NIB:0], sa[fstc_pkg::DIV_NIB-1:0]};
            b_next   = {b_reg[63-fstc_pkg::DIV_NIB:0], sb[fstc_pkg::DIV_NIB-1:0]};
            ra_next  = sa[fstc_pkg::REM_W+fstc_pkg::DIV_NIB-1:fstc_pkg::DIV_NIB];
            rb_next  = sb[fstc_pkg::REM_W+fstc_pkg::DIV_NIB-1:fstc_pkg::DIV_NIB];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == fstc_pkg::DIV_CNT_W'(fstc_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg  <= a_next;
        b_reg  <= b_next;
        ra_reg <= ra_next;
        rb_reg <= rb_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.dur_us = a_reg;
    assign rsp.gap_us = b_reg;

endmodule

FILE: hdl/flow_stats_tree_classifier_top.sv
// ----------------------------------------------------------------------------
// flow_stats_tree_classifier_top
// Per-flow packet statistics with decision tree classification.
// ----------------------------------------------------------------------------
// One beat is taken at a time. A node write goes to the finishing state and
// presents its result there once the output is free. A packet takes a flow
// record read and update, a run of the divide-by-1000 unit for duration and
// minimum gap, then one node memory read per tree level (up to 16), and then
// presents its result; with no model loaded the tree walk is skipped. After
// reset the block sweeps the 1024-entry flow memory, one entry per cycle,
// and takes no beat until the sweep is done.
module flow_stats_tree_classifier_top
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic               mode,
    input  logic [9:0]         flow_slot,
    input  logic [63:0]        timestamp_ns,
    input  logic [15:0]        packet_length,
    input  logic [7:0]         node_index,
    input  logic               node_is_leaf,
    input  logic [7:0]         node_label,
    input  logic signed [3:0]  node_feature,
    input  logic signed [63:0] node_threshold,
    input  logic signed [8:0]  node_left,
    input  logic signed [8:0]  node_right,

    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         class_label,
    output logic               new_flow,
    output logic               walk_fault
);

    typedef enum logic [7:0] {
        S_CLR  = 8'b0000_0001,
        S_IDLE = 8'b0000_0010,
        S_GAP  = 8'b0000_0100,
        S_UPD  = 8'b0000_1000,
        S_DIV  = 8'b0001_0000,
        S_WEV  = 8'b0010_0000,
        S_FIN  = 8'b0100_0000,
        S_SPR  = 8'b1000_0000
    } state_t;

    localparam int DEPTHW = fstc_pkg::DEPTH_W;

    state_t                           state_reg, state_next;
    logic [8:0]                       node_count_reg, node_count_next;
    logic [fstc_pkg::FLOW_SLOT_W:0]   clr_reg, clr_next;
    logic [fstc_pkg::FLOW_SLOT_W-1:0] slot_reg, slot_next;
    logic [63:0]                      ts_reg, ts_next;
    logic [15:0]                      len_reg, len_next;
    logic [63:0]                      gap_reg, gap_next;
    fstc_pkg::flow_rec_t              rec_reg, rec_next;
    logic [DEPTHW-1:0]                depth_reg, depth_next;
    logic [7:0]                       label_reg, label_next;
    logic                             new_reg, new_next;
    logic                             fault_reg, fault_next;
    logic                             out_valid_reg, out_valid_next;
    logic [7:0]                       class_label_reg, class_label_next;
    logic                             new_flow_reg, new_flow_next;
    logic                             walk_fault_reg, walk_fault_next;

    logic                             in_accept;
    logic                             cfg_wr;
    logic                             f_rd_en, f_wr_en;
    logic [fstc_pkg::FLOW_SLOT_W-1:0] f_wr_addr;
    fstc_pkg::flow_rec_t              f_rd_data, f_wr_data;
    logic                             t_rd_en, t_wr_en;
    logic [fstc_pkg::TREE_IDX_W-1:0]  t_rd_addr;
    fstc_pkg::tree_node_t             t_rd_data, t_wr_data;
    fstc_pkg::div_req_t               div_req;
    fstc_pkg::div_rsp_t               div_rsp;
    logic [63:0]                      feat [fstc_pkg::FEATURE_COUNT];

    fstc_flow_mem u_flow_mem
    (
        .clk     (clk),
        .rd_en   (f_rd_en),
        .rd_addr (flow_slot[fstc_pkg::FLOW_SLOT_W-1:0]),
        .rd_data (f_rd_data),
        .wr_en   (f_wr_en),
        .wr_addr (f_wr_addr),
        .wr_data (f_wr_data)
    );

    fstc_tree_mem u_tree_mem
    (
        .clk     (clk),
        .rd_en   (t_rd_en),
        .rd_addr (t_rd_addr),
        .rd_data (t_rd_data),
        .wr_en   (t_wr_en),
        .wr_addr (node_index[fstc_pkg::TREE_IDX_W-1:0]),
        .wr_data (t_wr_data)
    );

    fstc_div1000 u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && (paddr == fstc_pkg::NODE_COUNT_ADDR);
    assign prdata    = (paddr == fstc_pkg::NODE_COUNT_ADDR) ? {23'd0, node_count_reg} : 32'd0;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;

    assign t_wr_en   = in_accept && (mode == fstc_pkg::MODE_NODE);
    assign t_wr_data.links = node_is_leaf
        ? {1'b1, 21'd0, node_label}
        : {1'b0, 7'd0, node_feature, node_left, node_right};
    assign t_wr_data.threshold = node_threshold;

    assign f_rd_en   = in_accept && (mode == fstc_pkg::MODE_PACKET);

    always_comb
    begin
        for (int i = 0; i < fstc_pkg::FEATURE_COUNT; i++)
        begin
            feat[i] = 64'd0;
        end
        feat[0] = div_rsp.dur_us << fstc_pkg::FRAC_BITS;
        feat[1] = {32'd0, rec_reg.packets} << fstc_pkg::FRAC_BITS;
        feat[2] = {16'd0, rec_reg.bytes} << fstc_pkg::FRAC_BITS;
        feat[3] = {48'd0, rec_reg.len_max} << fstc_pkg::FRAC_BITS;
        feat[4] = {48'd0, rec_reg.len_min} << fstc_pkg::FRAC_BITS;
        feat[5] = (rec_reg.min_gap == fstc_pkg::NO_GAP) ? 64'd0
                : (div_rsp.gap_us << fstc_pkg::FRAC_BITS);
    end

    always_comb
    begin
        logic                    is_leaf;
        logic [3:0]              fsel;
        logic [8:0]              child;
        logic                    go_left;
        state_next       = state_reg;
        node_count_next  = cfg_wr ? pwdata[8:0] : node_count_reg;
        clr_next         = clr_reg;
        slot_next        = slot_reg;
        ts_next          = ts_reg;
        len_next         = len_reg;
        gap_next         = gap_reg;
        rec_next         = rec_reg;
        depth_next       = depth_reg;
        label_next       = label_reg;
        new_next         = new_reg;
        fault_next       = fault_reg;
        out_valid_next   = out_valid_reg && out_stall;
        class_label_next = class_label_reg;
        new_flow_next    = new_flow_reg;
        walk_fault_next  = walk_fault_reg;
        f_wr_en          = 1'b0;
        f_wr_addr        = slot_reg;
        f_wr_data        = rec_reg;
        t_rd_en          = 1'b0;
        t_rd_addr        = '0;
        div_req.start    = 1'b0;
        div_req.dur_ns   = ts_reg - rec_reg.start_time;
        div_req.gap_ns   = rec_reg.min_gap;
        is_leaf          = t_rd_data.links[29];
        fsel             = t_rd_data.links[21:18];
        go_left          = $signed(feat[fsel[fstc_pkg::FEAT_IDX_W-1:0]])
                           <= $signed(t_rd_data.threshold);
        child            = go_left ? t_rd_data.links[17:9] : t_rd_data.links[8:0];

        case (state_reg)
            S_CLR:
            begin
                f_wr_en   = 1'b1;
                f_wr_addr = clr_reg[fstc_pkg::FLOW_SLOT_W-1:0];
                f_wr_data = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == (fstc_pkg::FLOW_SLOT_W+1)'(fstc_pkg::FLOW_SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    slot_next = flow_slot[fstc_pkg::FLOW_SLOT_W-1:0];
                    ts_next   = timestamp_ns;
                    len_next  = packet_length;
                    if (mode == fstc_pkg::MODE_PACKET)
                    begin
                        state_next = S_GAP;
                    end
                    else
                    begin
                        label_next = 8'd0;
                        new_next   = 1'b0;
                        fault_next = 1'b0;
                        state_next = S_FIN;
                    end
                end
            end
            S_GAP:
            begin
                gap_next   = (ts_reg >= f_rd_data.last_time) ? ts_reg - f_rd_data.last_time
                                                             : 64'd0;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                rec_next.valid     = 1'b1;
                rec_next.last_time = ts_reg;
                if (!f_rd_data.valid)
                begin
                    rec_next.start_time = ts_reg;
                    rec_next.min_gap    = fstc_pkg::NO_GAP;
                    rec_next.packets    = 32'd1;
                    rec_next.bytes      = {32'd0, len_reg};
                    rec_next.len_max    = len_reg;
                    rec_next.len_min    = len_reg;
                    new_next            = 1'b1;
                end
                else
                begin
                    rec_next.start_time = f_rd_data.start_time;
                    rec_next.min_gap    = (gap_reg != 64'd0 && gap_reg < f_rd_data.min_gap)
                                          ? gap_reg : f_rd_data.min_gap;
                    rec_next.packets    = f_rd_data.packets + 32'd1;
                    rec_next.bytes      = f_rd_data.bytes + {32'd0, len_reg};
                    rec_next.len_max    = (len_reg > f_rd_data.len_max) ? len_reg
                                                                        : f_rd_data.len_max;
                    rec_next.len_min    = (len_reg < f_rd_data.len_min) ? len_reg
                                                                        : f_rd_data.len_min;
                    new_next            = 1'b0;
                end
                state_next = S_SPR;
            end
            S_SPR:
            begin
                f_wr_en       = 1'b1;
                div_req.start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (node_count_reg == 9'd0)
                    begin
                        label_next = 8'd0;
                        fault_next = 1'b1;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        t_rd_en    = 1'b1;
                        t_rd_addr  = '0;
                        depth_next = '0;
                        state_next = S_WEV;
                    end
                end
            end
            S_WEV:
            begin
                state_next = S_FIN;
                label_next = 8'd0;
                fault_next = 1'b1;
                if (is_leaf)
                begin
                    label_next = t_rd_data.links[7:0];
                    fault_next = 1'b0;
                end
                else if (!fsel[3] && ({1'b0, fsel} < 5'(fstc_pkg::FEATURE_COUNT))
                         && !child[8]
                         && (depth_reg != DEPTHW'(fstc_pkg::TREE_DEPTH - 1))
                         && (child < node_count_reg))
                begin
                    t_rd_en    = 1'b1;
                    t_rd_addr  = child[fstc_pkg::TREE_IDX_W-1:0];
                    depth_next = depth_reg + 1'b1;
                    state_next = S_WEV;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    class_label_next = label_reg;
                    new_flow_next    = new_reg;
                    walk_fault_next  = fault_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            node_count_reg <= 9'd0;
            clr_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            clr_reg        <= clr_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg        <= slot_next;
        ts_reg          <= ts_next;
        len_reg         <= len_next;
        gap_reg         <= gap_next;
        rec_reg         <= rec_next;
        depth_reg       <= depth_next;
        label_reg       <= label_next;
        new_reg         <= new_next;
        fault_reg       <= fault_next;
        class_label_reg <= class_label_next;
        new_flow_reg    <= new_flow_next;
        walk_fault_reg  <= walk_fault_next;
    end

    assign out_valid   = out_valid_reg;
    assign class_label = class_label_reg;
    assign new_flow    = new_flow_reg;
    assign walk_fault  = walk_fault_reg;

`ifndef SYNTHESIS
    a_fault_label: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && walk_fault |-> class_label == 8'd0)
        else $error("fault result carries a nonzero label");

    a_div_phase: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide phase");

    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLR |-> in_stall && !f_rd_en)
        else $error("beat taken during flow memory sweep");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WEV |-> depth_reg < DEPTHW'(fstc_pkg::TREE_DEPTH))
        else $error("tree walk beyond depth limit");
`endif

endmodule
